@@ src/lsqf_pkg.sv @@
package lsqf_pkg;

    localparam int MaxSlotsDef = 16;
    localparam int TagBitsDef  = 16;

    localparam logic [4:0] ActiveReset  = 5'd16;
    localparam logic [7:0] LatencyReset = 8'd3;

    localparam logic [0:0] CfgActive  = 1'd0;
    localparam logic [0:0] CfgLatency = 1'd1;

    typedef enum logic [3:0] {
        FN_ALLOC   = 4'd0,
        FN_TAG     = 4'd1,
        FN_ADDR    = 4'd2,
        FN_SDATA   = 4'd3,
        FN_SREADY  = 4'd4,
        FN_LDONE   = 4'd5,
        FN_TICK    = 4'd6,
        FN_FREE    = 4'd7,
        FN_FLUSH   = 4'd8,
        FN_COMMIT  = 4'd9,
        FN_FULL    = 4'd10,
        FN_UNRES   = 4'd11,
        FN_FORWARD = 4'd12,
        FN_READ    = 4'd13
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WB   = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    // Slot flags
    typedef struct packed {
        logic done;
        logic dready;
        logic aready;
        logic store;
        logic busy;
    } t_flags;

endpackage

@@ src/load_store_queue_forwarding_core.sv @@
// Single-slot operations go from accept through the scan state to the result state;
// scans evaluate and write back each active slot in turn, stopping early at the first
// hit for alloc, free, full and unresolved, and for tick at the first counter to reach
// zero. One beat at a time: the next is taken the cycle after the result beat leaves.
// Reset (synchronous, active low): all slot copies empty, state and config to defaults.
module load_store_queue_forwarding_core
    import lsqf_pkg::*;
#(
    parameter int MAX_SLOTS = MaxSlotsDef,
    parameter int TAG_BITS  = TagBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_func,
    input  logic [3:0]         i_entry_index,
    input  logic [5:0]         i_rob_index,
    input  logic               i_is_store_in,
    input  logic signed [15:0] i_tag_in,
    input  logic [31:0]        i_address_in,
    input  logic [31:0]        i_data_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic [3:0]         o_slot,
    output logic [31:0]        o_value_out,
    output logic               o_busy_out,
    output logic               o_store_out,
    output logic               o_address_ready_out,
    output logic               o_data_present_out,
    output logic               o_completed_out,
    output logic [31:0]        o_address_out,
    output logic signed [6:0]  o_rob_out,
    output logic signed [15:0] o_tag_out
);
    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int NCAP = (MAX_SLOTS < 31) ? MAX_SLOTS : 31;

    // Two copies (committed, pending) per slot; reset clears all but ROB and tag (all ones).
    t_flags                    r_of [MAX_SLOTS];
    t_flags                    r_nf [MAX_SLOTS];
    logic [31:0]               r_oaddr [MAX_SLOTS];
    logic [31:0]               r_naddr [MAX_SLOTS];
    logic [31:0]               r_oval [MAX_SLOTS];
    logic [31:0]               r_nval [MAX_SLOTS];
    logic [6:0]                r_orob [MAX_SLOTS];
    logic [6:0]                r_nrob [MAX_SLOTS];
    logic signed [TAG_BITS-1:0] r_otag [MAX_SLOTS];
    logic signed [TAG_BITS-1:0] r_ntag [MAX_SLOTS];
    logic [7:0]                r_ocnt [MAX_SLOTS];
    logic [7:0]                r_ncnt [MAX_SLOTS];

    logic [4:0]  r_active;
    logic [7:0]  r_latency;
    t_state      r_state;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_cur;

    // Held request
    logic [3:0]  r_func;
    logic [3:0]  r_idx;
    logic [5:0]  r_rob;
    logic        r_st;
    logic signed [15:0] r_tag;
    logic [31:0] r_addr;
    logic [31:0] r_data;

    // Result
    logic        r_found;
    logic [3:0]  r_slot;
    logic [31:0] r_value;
    logic [4:0]  r_rflags;
    logic [31:0] r_raddr;
    logic [6:0]  r_rrob;
    logic [15:0] r_rtag;
    logic signed [TAG_BITS-1:0] r_best;
    logic        r_have_best;
    logic        r_hit;
    logic        r_wdec;

    logic w_hit, w_dec_zero, w_valid_idx, w_fin;
    logic [IW-1:0] w_ci;
    logic [IW-1:0] w_idx;

    assign w_ci  = r_i[IW-1:0];
    assign w_idx = IW'(r_idx);
    assign w_valid_idx = (32'(r_idx) < MAX_SLOTS);

    lsqf_slot_eval #(.TAG_BITS(TAG_BITS)) u_eval (
        .i_func(r_func), .i_of(r_of[w_ci]), .i_nf(r_nf[w_ci]),
        .i_otag(r_otag[w_ci]), .i_ntag(r_ntag[w_ci]),
        .i_ocnt(r_ocnt[w_ci]), .i_ncnt(r_ncnt[w_ci]),
        .i_oaddr(r_oaddr[w_ci]), .i_nrob(r_nrob[w_ci]),
        .i_rob(r_rob), .i_tag(r_tag), .i_addr(r_addr),
        .i_best(r_best), .i_have_best(r_have_best),
        .o_hit(w_hit), .o_dec_zero(w_dec_zero)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_found = r_found;
    assign o_slot  = r_slot;
    assign o_value_out = r_value;
    assign o_busy_out  = r_rflags[0];
    assign o_store_out = r_rflags[1];
    assign o_address_ready_out = r_rflags[2];
    assign o_data_present_out  = r_rflags[3];
    assign o_completed_out     = r_rflags[4];
    assign o_address_out = r_raddr;
    assign o_rob_out = r_rrob;
    assign o_tag_out = r_rtag;

    // Scan ends at the last active slot; write back may stop it early for some functions.
    assign w_fin = (r_i >= r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= ActiveReset;
            r_latency <= LatencyReset;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_of[k] <= '0; r_nf[k] <= '0;
                r_oaddr[k] <= '0; r_naddr[k] <= '0;
                r_oval[k] <= '0; r_nval[k] <= '0;
                r_orob[k] <= '1; r_nrob[k] <= '1;
                r_otag[k] <= '1; r_ntag[k] <= '1;
                r_ocnt[k] <= '0; r_ncnt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgActive:  r_active  <= i_cfg_data[4:0];
                    CfgLatency: r_latency <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_func <= i_func; r_idx <= i_entry_index; r_rob <= i_rob_index;
                        r_st <= i_is_store_in; r_tag <= i_tag_in;
                        r_addr <= i_address_in; r_data <= i_data_in;
                        r_i <= '0;
                        r_n <= (32'(r_active) > NCAP) ? CW'(MAX_SLOTS) : CW'(r_active);
                        r_found <= (i_func == FN_FULL) || (i_func == FN_COMMIT);
                        r_slot <= '0; r_value <= '0; r_rflags <= '0;
                        r_raddr <= '0; r_rrob <= '0; r_rtag <= '0;
                        r_have_best <= 1'b0; r_best <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    case (r_func) inside
                        FN_TAG, FN_ADDR, FN_SDATA, FN_SREADY, FN_LDONE: begin
                            if (w_valid_idx) begin
                                r_found <= 1'b1;
                                case (r_func)
                                    FN_TAG: r_ntag[w_idx] <= TAG_BITS'(r_tag);
                                    FN_ADDR: begin
                                        r_naddr[w_idx] <= r_addr;
                                        r_nf[w_idx].aready <= 1'b1;
                                        r_ncnt[w_idx] <= r_latency;
                                    end
                                    FN_SDATA: begin
                                        r_nval[w_idx] <= r_data;
                                        r_nf[w_idx].dready <= 1'b1;
                                    end
                                    FN_SREADY: r_nf[w_idx].done <= 1'b1;
                                    default: begin
                                        r_nf[w_idx].done <= 1'b1;
                                        r_nval[w_idx] <= r_data;
                                    end
                                endcase
                            end
                            r_state <= ST_OUT;
                        end
                        FN_READ: begin
                            if (w_valid_idx) begin
                                r_found <= 1'b1;
                                r_value <= r_oval[w_idx];
                                r_rflags <= r_of[w_idx];
                                r_raddr <= r_oaddr[w_idx];
                                r_rrob <= r_orob[w_idx];
                                r_rtag <= 16'(r_otag[w_idx]);
                            end else begin
                                r_rrob <= '1;
                                r_rtag <= '1;
                            end
                            r_state <= ST_OUT;
                        end
                        FN_ALLOC, FN_TICK, FN_FREE, FN_FLUSH, FN_COMMIT,
                        FN_FULL, FN_UNRES, FN_FORWARD: begin
                            if (w_fin) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_cur <= w_ci;
                                r_hit <= w_hit;
                                r_wdec <= w_dec_zero;
                                r_state <= ST_WB;
                            end
                        end
                        default: r_state <= ST_OUT;
                    endcase
                end
                ST_WB: begin
                    // Apply the verdict of the slot just evaluated
                    r_i <= r_i + 1'b1;
                    r_state <= ST_SCAN;
                    case (r_func) inside
                        FN_ALLOC: if (r_hit) begin
                            r_nf[r_cur] <= '{busy: 1'b1, store: r_st, default: 1'b0};
                            r_naddr[r_cur] <= '0; r_nval[r_cur] <= '0;
                            r_nrob[r_cur] <= {1'b0, r_rob};
                            r_ntag[r_cur] <= '1; r_ncnt[r_cur] <= '0;
                            r_found <= 1'b1; r_slot <= 4'(r_cur);
                            r_state <= ST_OUT;
                        end
                        FN_TICK: if (r_hit) begin
                            r_ncnt[r_cur] <= r_ncnt[r_cur] - 8'd1;
                            if (r_wdec) begin
                                if (r_of[r_cur].store) r_nf[r_cur].done <= 1'b1;
                                r_found <= 1'b1; r_slot <= 4'(r_cur);
                                r_state <= ST_OUT;
                            end
                        end
                        FN_FREE, FN_FLUSH: if (r_hit) begin
                            r_nf[r_cur] <= '0; r_naddr[r_cur] <= '0; r_nval[r_cur] <= '0;
                            r_nrob[r_cur] <= '1; r_ntag[r_cur] <= '1; r_ncnt[r_cur] <= '0;
                            r_found <= 1'b1;
                            if (r_func == FN_FREE) begin
                                r_slot <= 4'(r_cur);
                                r_state <= ST_OUT;
                            end
                        end
                        FN_COMMIT: begin
                            r_of[r_cur] <= r_nf[r_cur]; r_oaddr[r_cur] <= r_naddr[r_cur];
                            r_oval[r_cur] <= r_nval[r_cur]; r_orob[r_cur] <= r_nrob[r_cur];
                            r_otag[r_cur] <= r_ntag[r_cur]; r_ocnt[r_cur] <= r_ncnt[r_cur];
                        end
                        FN_FULL: if (r_hit) begin
                            r_found <= 1'b0;
                            r_state <= ST_OUT;
                        end
                        FN_UNRES: if (r_hit) begin
                            r_found <= 1'b1;
                            r_state <= ST_OUT;
                        end
                        default: if (r_hit) begin
                            r_found <= 1'b1;
                            r_value <= r_oval[r_cur];
                            r_best <= r_otag[r_cur];
                            r_have_best <= 1'b1;
                        end
                    endcase
                end
                ST_OUT: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value_out) && $stable(o_found))
        else $error("result changed while stalled");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> (r_i < r_n))
        else $error("scan past active slots");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |=> o_stall)
        else $error("accepting during scan");
endmodule

@@ src/lsqf_slot_eval.sv @@
// Per-slot decision unit: one slot pair in, one verdict out.
module lsqf_slot_eval
    import lsqf_pkg::*;
#(
    parameter int TAG_BITS = TagBitsDef
) (
    input  logic [3:0]           i_func,
    input  t_flags               i_of,
    input  t_flags               i_nf,
    input  logic signed [TAG_BITS-1:0] i_otag,
    input  logic signed [TAG_BITS-1:0] i_ntag,
    input  logic [7:0]           i_ocnt,
    input  logic [7:0]           i_ncnt,
    input  logic [31:0]          i_oaddr,
    input  logic [6:0]           i_nrob,
    input  logic [5:0]           i_rob,
    input  logic signed [15:0]   i_tag,
    input  logic [31:0]          i_addr,
    input  logic signed [TAG_BITS-1:0] i_best,
    input  logic                 i_have_best,
    output logic                 o_hit,
    output logic                 o_dec_zero
);
    logic signed [31:0] w_ot, w_nt, w_qt, w_bt;

    always_comb begin
        w_ot = 32'(i_otag);
        w_nt = 32'(i_ntag);
        w_qt = 32'(i_tag);
        w_bt = 32'(i_best);
        o_hit = 1'b0;
        o_dec_zero = 1'b0;
        case (i_func)
            FN_ALLOC:  o_hit = !i_of.busy && !i_nf.busy;
            FN_TICK: begin
                o_hit = i_of.busy && i_nf.busy && (i_ntag == i_otag) && !i_of.done
                        && i_of.aready && !(i_of.store && !i_of.dready)
                        && (i_ocnt != 8'd0) && (i_ncnt != 8'd0);
                o_dec_zero = o_hit && (i_ncnt == 8'd1);
            end
            FN_FREE:   o_hit = i_nf.busy && (i_nrob == {1'b0, i_rob});
            FN_FLUSH:  o_hit = i_nf.busy && (w_nt > w_qt);
            FN_FULL:   o_hit = !i_of.busy;
            FN_UNRES:  o_hit = i_of.busy && i_of.store && (w_ot >= 0) && (w_ot < w_qt)
                               && !i_of.aready;
            FN_FORWARD: o_hit = i_of.busy && (w_ot >= 0) && (w_ot < w_qt) && i_of.store
                                && i_of.aready && i_of.dready && (i_oaddr == i_addr)
                                && (!i_have_best || w_ot > w_bt);
            default:   o_hit = 1'b0;
        endcase
    end
endmodule
